>>> rtl/core/nfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_pkg - shared types and arithmetic for the Newton fractal pixel
// Q8.56 constants, saturating add and subtract, sign and magnitude helpers
// and the outcome codes.
// ----------------------------------------------------------------------------
package nfp_pkg;

  localparam int unsigned QW = 64;

  localparam logic signed [QW-1:0] QMAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [QW-1:0] QMIN     = 64'sh8000_0000_0000_0000;
  localparam logic signed [QW-1:0] QONE     = 64'sh0100_0000_0000_0000;
  localparam logic signed [QW-1:0] QHALF    = 64'sh0080_0000_0000_0000;
  localparam logic signed [QW-1:0] QFOUR    = 64'sh0400_0000_0000_0000;
  localparam logic signed [QW-1:0] ROOT_IM  = 64'sd62403706972431696;
  localparam logic signed [QW-1:0] CONV_MAX = 64'sd720575940;

  localparam logic [15:0] MAX_ITER_RST = 16'd64;

  typedef enum logic [1:0] {
    OUT_CONV  = 2'd0,
    OUT_ESC   = 2'd1,
    OUT_LIMIT = 2'd2,
    OUT_ZDER  = 2'd3
  } nfp_outcome_e;

  // one queued start point, widened to Q8.56
  typedef struct packed {
    logic signed [QW-1:0] re;
    logic signed [QW-1:0] im;
  } nfp_point_t;

  // one finished pixel
  typedef struct packed {
    nfp_outcome_e outcome;
    logic [1:0]   root;
    logic [3:0]   palette;
    logic [15:0]  iter;
  } nfp_result_t;

  function automatic logic signed [QW-1:0] sadd(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [QW-1:0] s;
    s = a + b;
    if (!a[QW-1] && !b[QW-1] && s[QW-1]) return QMAX;
    if (a[QW-1] && b[QW-1] && !s[QW-1]) return QMIN;
    return s;
  endfunction

  function automatic logic signed [QW-1:0] ssub(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [QW-1:0] s;
    s = a - b;
    if (!a[QW-1] && b[QW-1] && s[QW-1]) return QMAX;
    if (a[QW-1] && !b[QW-1] && !s[QW-1]) return QMIN;
    return s;
  endfunction

  function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] a);
    logic [QW-1:0] u;
    u = a;
    return a[QW-1] ? (~u + 64'd1) : u;
  endfunction

  // signed value from sign and magnitude, saturated
  function automatic logic signed [QW-1:0] from_mag(input logic neg,
                                                     input logic [QW-1:0] m,
                                                     input logic ovf);
    logic [QW-1:0] n;
    n = ~m + 64'd1;
    if (!neg) return (ovf || m[QW-1]) ? QMAX : signed'(m);
    if (ovf || (m > 64'h8000_0000_0000_0000)) return QMIN;
    return signed'(n);
  endfunction

  function automatic logic signed [QW-1:0] root_re(input logic [1:0] r);
    case (r)
      2'd0:    return QONE;
      default: return -QHALF;
    endcase
  endfunction

  function automatic logic signed [QW-1:0] root_im(input logic [1:0] r);
    case (r)
      2'd1:    return ROOT_IM;
      2'd2:    return -ROOT_IM;
      default: return '0;
    endcase
  endfunction

endpackage

>>> rtl/core/nfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_front - command intake
// Takes start points, widens Q4.28 to Q8.56 and holds them in a two-word
// queue until the back end picks them up.
// ----------------------------------------------------------------------------
module nfp_front import nfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] start_real_i,
  input  logic signed [31:0] start_imag_i,
  output logic               pt_valid_o,
  input  logic               pt_take_i,
  output nfp_point_t         pt_o
);

  nfp_point_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign busy       = (cnt_q == 2'd2);
  assign push       = start && !busy;
  assign pt_valid_o = (cnt_q != 2'd0);
  assign pop        = pt_take_i && pt_valid_o;
  assign pt_o       = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // queue storage, widened on entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].re <= {{4{start_real_i[31]}}, start_real_i, 28'd0};
      mem_q[wr_ptr_q].im <= {{4{start_imag_i[31]}}, start_imag_i, 28'd0};
    end
  end

endmodule

>>> rtl/core/nfp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_mul - Q8.56 multiplier
// Sign-magnitude product built from four 32x32 partial products, one per
// cycle, then rounded to nearest (ties away) and saturated.
// ----------------------------------------------------------------------------
module nfp_mul import nfp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [QW-1:0]  a_i,
  input  logic signed [QW-1:0]  b_i,
  output logic                  done_o,
  output logic signed [QW-1:0]  p_o
);

  logic                 run_q;
  logic [2:0]           ph_q;
  logic [QW-1:0]        x_q, y_q;
  logic                 neg_q;
  logic [2*QW-1:0]      acc_q;
  logic                 done_q;
  logic signed [QW-1:0] p_q;

  logic [31:0]     xs, ys;
  logic [63:0]     pp;
  logic [2*QW-1:0] pp_sh, rnd;

  // partial product for the current phase
  always_comb begin
    xs    = ph_q[1] ? x_q[63:32] : x_q[31:0];
    ys    = ph_q[0] ? y_q[63:32] : y_q[31:0];
    pp    = xs * ys;
    pp_sh = {64'd0, pp} << (7'd32 * ({6'd0, ph_q[1]} + {6'd0, ph_q[0]}));
    rnd   = acc_q + (128'd1 << 55);
  end

  // sequence: phases 0..3 accumulate, phase 4 rounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      ph_q   <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        ph_q  <= 3'd0;
      end else if (run_q) begin
        if (ph_q == 3'd4) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          ph_q <= ph_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= mag(a_i);
      y_q   <= mag(b_i);
      neg_q <= a_i[QW-1] ^ b_i[QW-1];
      acc_q <= '0;
    end else if (run_q) begin
      if (ph_q == 3'd4) p_q <= from_mag(neg_q, rnd[119:56], |rnd[127:120]);
      else              acc_q <= acc_q + pp_sh;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

>>> rtl/core/nfp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_div - Q8.56 quotient (t * 2^56) / d for d > 0
// Restoring division, one quotient bit per cycle, then a rounding step
// (nearest, ties away) with saturation.
// ----------------------------------------------------------------------------
module nfp_div import nfp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [QW-1:0]  t_i,
  input  logic signed [QW-1:0]  d_i,
  output logic                  done_o,
  output logic signed [QW-1:0]  q_o
);

  logic                 run_q, rnd_q, done_q;
  logic [6:0]           cnt_q;
  logic [2*QW-1:0]      n_q;
  logic [QW-1:0]        d_q, rem_q, quo_q;
  logic                 ovf_q, neg_q;
  logic signed [QW-1:0] q_q;

  logic [QW-1:0] r2, rem2;
  logic          ge, up;

  always_comb begin
    r2   = {rem_q[QW-2:0], n_q[2*QW-1]};
    ge   = (r2 >= d_q);
    rem2 = {rem_q[QW-2:0], 1'b0};
    up   = !ovf_q && (rem2 >= d_q);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 7'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          run_q <= 1'b0;
          rnd_q <= 1'b1;
        end
      end else if (rnd_q) begin
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {8'd0, mag(t_i), 56'd0};
      d_q   <= d_i;
      neg_q <= t_i[QW-1];
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (run_q) begin
      n_q   <= {n_q[2*QW-2:0], 1'b0};
      ovf_q <= ovf_q | quo_q[QW-1];
      quo_q <= {quo_q[QW-2:0], ge};
      rem_q <= ge ? (r2 - d_q) : r2;
    end else if (rnd_q) begin
      if (up && (&quo_q)) q_q <= from_mag(neg_q, quo_q, 1'b1);
      else if (up)        q_q <= from_mag(neg_q, quo_q + 64'd1, 1'b0);
      else                q_q <= from_mag(neg_q, quo_q, ovf_q);
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

>>> rtl/core/nfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_back - Newton iteration sequencer
// Steps through the checks and one Newton step per iteration, sharing one
// multiplier and one divider; emits one result strobe per point.
// ----------------------------------------------------------------------------
module nfp_back import nfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] max_iter_i,
  input  logic        pt_valid_i,
  output logic        pt_take_o,
  input  nfp_point_t  pt_i,
  output logic        res_valid_o,
  output nfp_result_t res_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_E1, S_E2, S_R1, S_R2, S_Z1, S_Z2, S_Z3, S_D,
    S_N1, S_N2, S_C1, S_C2, S_C3, S_C4, S_T1, S_T2, S_T3, S_T4, S_Q1, S_Q2
  } state_e;

  state_e               st_q, st_d;
  logic                 pend_q, pend_d;
  logic [1:0]           r_q, r_d;
  logic [15:0]          it_q, it_d;
  logic signed [QW-1:0] zr_q, zr_d, zi_q, zi_d, acc_q, acc_d;
  logic signed [QW-1:0] z2r_q, z2r_d, z2i_q, z2i_d, dr_q, dr_d, di_q, di_d;
  logic signed [QW-1:0] dn_q, dn_d, z3r_q, z3r_d, z3i_q, z3i_d;
  logic signed [QW-1:0] tr_q, tr_d, ti_q, ti_d;
  logic                 rv_q, rv_d;
  nfp_result_t          res_q, res_d;

  logic                 mul_start, mul_done, div_start, div_done, is_mul;
  logic signed [QW-1:0] ma, mb, mp, dt, dq, nr, n2;

  // shared units
  nfp_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ma), .b_i(mb),
    .done_o(mul_done), .p_o(mp)
  );

  nfp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .t_i(dt), .d_i(dn_q),
    .done_o(div_done), .q_o(dq)
  );

  // multiplier operand selection
  always_comb begin
    nr     = ssub(z3r_q, QONE);
    is_mul = 1'b1;
    ma     = zr_q;
    mb     = zr_q;
    case (st_q)
      S_E1, S_Z1: begin ma = zr_q; mb = zr_q; end
      S_E2, S_Z2: begin ma = zi_q; mb = zi_q; end
      S_R1: begin
        ma = ssub(zr_q, root_re(r_q));
        mb = ma;
      end
      S_R2: begin
        ma = ssub(zi_q, root_im(r_q));
        mb = ma;
      end
      S_Z3:    begin ma = zr_q;  mb = zi_q; end
      S_N1:    begin ma = dr_q;  mb = dr_q; end
      S_N2:    begin ma = di_q;  mb = di_q; end
      S_C1:    begin ma = z2r_q; mb = zr_q; end
      S_C2:    begin ma = z2i_q; mb = zi_q; end
      S_C3:    begin ma = z2r_q; mb = zi_q; end
      S_C4:    begin ma = z2i_q; mb = zr_q; end
      S_T1:    begin ma = nr;    mb = dr_q; end
      S_T2:    begin ma = z3i_q; mb = di_q; end
      S_T3:    begin ma = z3i_q; mb = dr_q; end
      S_T4:    begin ma = nr;    mb = di_q; end
      default: is_mul = 1'b0;
    endcase
    mul_start = is_mul && !pend_q;
    dt        = (st_q == S_Q2) ? ti_q : tr_q;
    div_start = ((st_q == S_Q1) || (st_q == S_Q2)) && !pend_q;
    n2        = sadd(acc_q, mp);
  end

  // next state
  always_comb begin
    st_d  = st_q;   pend_d = pend_q; r_d = r_q;   it_d = it_q;
    zr_d  = zr_q;   zi_d   = zi_q;   acc_d = acc_q;
    z2r_d = z2r_q;  z2i_d  = z2i_q;  dr_d  = dr_q; di_d = di_q; dn_d = dn_q;
    z3r_d = z3r_q;  z3i_d  = z3i_q;  tr_d  = tr_q; ti_d = ti_q;
    rv_d  = 1'b0;   res_d  = res_q;
    pt_take_o = 1'b0;

    if (mul_start || div_start) pend_d = 1'b1;
    if ((is_mul && pend_q && mul_done) || (!is_mul && pend_q && div_done))
      pend_d = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (pt_valid_i) begin
          pt_take_o = 1'b1;
          zr_d = pt_i.re;
          zi_d = pt_i.im;
          it_d = '0;
          st_d = S_CHK;
        end
      end
      S_CHK: begin
        if (it_q < max_iter_i) begin
          st_d = S_E1;
        end else begin
          rv_d  = 1'b1;
          res_d = '{outcome: OUT_LIMIT, root: 2'd0, palette: 4'd0, iter: it_q};
          st_d  = S_IDLE;
        end
      end
      S_D: begin
        dr_d = sadd(sadd(z2r_q, z2r_q), z2r_q);
        di_d = sadd(sadd(z2i_q, z2i_q), z2i_q);
        st_d = S_N1;
      end
      S_Q1: begin
        if (pend_q && div_done) begin
          zr_d = ssub(zr_q, dq);
          st_d = S_Q2;
        end
      end
      S_Q2: begin
        if (pend_q && div_done) begin
          zi_d = ssub(zi_q, dq);
          it_d = it_q + 16'd1;
          st_d = S_CHK;
        end
      end
      default: begin
        // multiplier steps advance on the product
        if (pend_q && mul_done) begin
          acc_d = mp;
          case (st_q)
            S_E1: st_d = S_E2;
            S_E2: begin
              if (n2 > QFOUR) begin
                rv_d  = 1'b1;
                res_d = '{outcome: OUT_ESC, root: 2'd0, palette: 4'd0, iter: it_q};
                st_d  = S_IDLE;
              end else begin
                r_d  = 2'd0;
                st_d = S_R1;
              end
            end
            S_R1: st_d = S_R2;
            S_R2: begin
              if (n2 <= CONV_MAX) begin
                rv_d  = 1'b1;
                res_d = '{outcome: OUT_CONV, root: r_q,
                          palette: 4'({2'd0, r_q} * 4'd5) + it_q[3:0], iter: it_q};
                st_d  = S_IDLE;
              end else if (r_q == 2'd2) begin
                st_d = S_Z1;
              end else begin
                r_d  = r_q + 2'd1;
                st_d = S_R1;
              end
            end
            S_Z1: st_d = S_Z2;
            S_Z2: begin z2r_d = ssub(acc_q, mp); st_d = S_Z3; end
            S_Z3: begin z2i_d = sadd(mp, mp);    st_d = S_D;  end
            S_N1: st_d = S_N2;
            S_N2: begin
              dn_d = n2;
              if (n2 <= 0) begin
                rv_d  = 1'b1;
                res_d = '{outcome: OUT_ZDER, root: 2'd0, palette: 4'd0, iter: it_q};
                st_d  = S_IDLE;
              end else begin
                st_d = S_C1;
              end
            end
            S_C1: st_d = S_C2;
            S_C2: begin z3r_d = ssub(acc_q, mp); st_d = S_C3; end
            S_C3: st_d = S_C4;
            S_C4: begin z3i_d = n2;              st_d = S_T1; end
            S_T1: st_d = S_T2;
            S_T2: begin tr_d = n2;               st_d = S_T3; end
            S_T3: st_d = S_T4;
            S_T4: begin ti_d = ssub(acc_q, mp);  st_d = S_Q1; end
            default: st_d = S_IDLE;
          endcase
        end
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pend_q <= 1'b0;
      rv_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      pend_q <= pend_d;
      rv_q   <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;   it_q  <= it_d;  zr_q  <= zr_d;  zi_q <= zi_d; acc_q <= acc_d;
    z2r_q <= z2r_d; z2i_q <= z2i_d; dr_q  <= dr_d;  di_q <= di_d; dn_q  <= dn_d;
    z3r_q <= z3r_d; z3i_q <= z3i_d; tr_q  <= tr_d;  ti_q <= ti_d; res_q <= res_d;
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/newton_fractal_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_fractal_pixel - Newton iteration for z^3 - 1 on one start point
// Each Newton step takes 21 multiplies on the one shared multiplier, two
//   divisions and control states; the checks that stop it come on top.
// One point at a time; a two-word queue takes points ahead.
// Reset: queue empty, sequencer idle, max_iterations back to 64.
// Results strobe for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module newton_fractal_pixel import nfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] start_real_i,
  input  logic signed [31:0] start_imag_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [1:0]         outcome_o,
  output logic [1:0]         root_number_o,
  output logic [3:0]         palette_index_o,
  output logic [15:0]        iterations_o
);

  logic        [15:0] max_iter_q;
  logic               pt_valid, pt_take;
  nfp_point_t         pt;
  nfp_result_t        res;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_iter_q <= cfg_data_i;
    end
  end

  nfp_front u_front (
    .clk_i, .rst_ni, .start, .busy, .start_real_i, .start_imag_i,
    .pt_valid_o(pt_valid), .pt_take_i(pt_take), .pt_o(pt)
  );

  nfp_back u_back (
    .clk_i, .rst_ni, .max_iter_i(max_iter_q),
    .pt_valid_i(pt_valid), .pt_take_o(pt_take), .pt_i(pt),
    .res_valid_o(result_valid_o), .res_o(res)
  );

  assign outcome_o       = res.outcome;
  assign root_number_o   = res.root;
  assign palette_index_o = res.palette;
  assign iterations_o    = res.iter;

endmodule

>>> rtl/core/nfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_checker - port-level checks for the Newton fractal pixel
// Result strobe shape and consistency of the result word fields.
// ----------------------------------------------------------------------------
module nfp_checker import nfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [1:0]  outcome_o,
  input logic [1:0]  root_number_o,
  input logic [3:0]  palette_index_o,
  input logic [15:0] iterations_o
);

  // a new point must pass through the check states first, so strobes never abut
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // black pixel and root 0 unless converged
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (outcome_o != OUT_CONV)) |->
      (palette_index_o == 4'd0) && (root_number_o == 2'd0))
    else $error("non-converged word with colour or root");

  // palette follows root and step count
  a_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (outcome_o == OUT_CONV)) |->
      (palette_index_o == 4'(4'({2'd0, root_number_o} * 4'd5) + iterations_o[3:0])))
    else $error("palette index mismatch");

  // only three roots exist
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (root_number_o != 2'd3))
    else $error("root number out of range");

endmodule

bind newton_fractal_pixel nfp_checker u_nfp_checker (.*);

>>> tb/sv/newton_fractal_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_fractal_pixel_checker - scoreboard for the Newton fractal pixel
// Watches the point, register and result channels. Each accepted point is
// run through a fixed-point Newton predictor. Each pixel word that comes out
// is compared, field by field, with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module newton_fractal_pixel_checker import nfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [31:0] start_real_i,
  input  logic signed [31:0] start_imag_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               result_valid_i,
  input  logic [1:0]         outcome_i,
  input  logic [1:0]         root_number_i,
  input  logic [3:0]         palette_index_i,
  input  logic [15:0]        iterations_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef logic signed [63:0] q_t;

  logic [15:0]  step_limit;
  nfp_result_t  pixels_due[$];

  // clamp a 65-bit sum back to Q8.56
  function automatic q_t clamp65(input logic signed [64:0] s);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return QMAX;
    if (s < -65'sh0_8000_0000_0000_0000) return QMIN;
    return s[63:0];
  endfunction

  function automatic q_t q_add(input q_t a, input q_t b);
    return clamp65({a[63], a} + {b[63], b});
  endfunction

  function automatic q_t q_sub(input q_t a, input q_t b);
    return clamp65({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] abs64(input q_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic q_t signed_of(input logic neg, input logic [63:0] m, input logic ovf);
    if (!neg) return (ovf || m[63]) ? QMAX : q_t'(m);
    if (ovf || m > 64'h8000_0000_0000_0000) return QMIN;
    return q_t'(-m);
  endfunction

  // exact product, rounded half away from zero
  function automatic q_t q_mul(input q_t a, input q_t b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = p + (128'd1 << 55);
    return signed_of(a[63] ^ b[63], p[119:56], |p[127:120]);
  endfunction

  // (t * 2^56) / d for d > 0, rounded half away from zero
  function automatic q_t q_div(input q_t t, input q_t d);
    logic [127:0] num, quo, rem;
    logic         ovf;
    num = {64'd0, abs64(t)} << 56;
    quo = num / {64'd0, d};
    rem = num % {64'd0, d};
    ovf = |quo[127:64];
    if (!ovf && (rem << 1) >= {64'd0, d}) begin
      if (&quo[63:0]) ovf = 1'b1;
      else quo = quo + 128'd1;
    end
    return signed_of(t[63], quo[63:0], ovf);
  endfunction

  function automatic q_t mod_sq(input q_t re, input q_t im);
    return q_add(q_mul(re, re), q_mul(im, im));
  endfunction

  function automatic nfp_result_t predict_pixel(input logic signed [31:0] sr,
                                                input logic signed [31:0] si,
                                                input logic [15:0] limit);
    nfp_result_t px;
    q_t zr, zi, z2r, z2i, dr, di, dn, z3r, z3i, nr, tr, ti, cr, ci;
    int steps;
    logic stop;
    zr = {{4{sr[31]}}, sr, 28'd0};
    zi = {{4{si[31]}}, si, 28'd0};
    px = '{outcome: OUT_LIMIT, root: 2'd0, palette: 4'd0, iter: 16'd0};
    steps = 0;
    stop = 1'b0;
    while (!stop && steps < limit) begin
      if (mod_sq(zr, zi) > QFOUR) begin
        px.outcome = OUT_ESC;
        stop = 1'b1;
      end
      // roots tried in order: one, upper, lower
      for (int r = 0; r < 3 && !stop; r++) begin
        cr = (r == 0) ? QONE : -QHALF;
        ci = (r == 0) ? 64'sd0 : ((r == 1) ? ROOT_IM : -ROOT_IM);
        if (mod_sq(q_sub(zr, cr), q_sub(zi, ci)) <= CONV_MAX) begin
          px.outcome = OUT_CONV;
          px.root    = 2'(r);
          px.palette = 4'(r * 5 + steps);
          stop = 1'b1;
        end
      end
      if (!stop) begin
        z2r = q_sub(q_mul(zr, zr), q_mul(zi, zi));
        z2i = q_add(q_mul(zr, zi), q_mul(zr, zi));
        dr  = q_add(q_add(z2r, z2r), z2r);
        di  = q_add(q_add(z2i, z2i), z2i);
        dn  = mod_sq(dr, di);
        if (dn <= 0) begin
          px.outcome = OUT_ZDER;
          stop = 1'b1;
        end else begin
          z3r = q_sub(q_mul(z2r, zr), q_mul(z2i, zi));
          z3i = q_add(q_mul(z2r, zi), q_mul(z2i, zr));
          nr  = q_sub(z3r, QONE);
          tr  = q_add(q_mul(nr, dr), q_mul(z3i, di));
          ti  = q_sub(q_mul(z3i, dr), q_mul(nr, di));
          zr  = q_sub(zr, q_div(tr, dn));
          zi  = q_sub(zi, q_div(ti, dn));
          steps++;
        end
      end
    end
    px.iter = 16'(steps);
    return px;
  endfunction

  assign pending_o = pixels_due.size();

  // register writes, points taken, pixel words checked
  always @(posedge clk_i or negedge rst_ni) begin
    nfp_result_t want;
    if (!rst_ni) begin
      step_limit = MAX_ITER_RST;
      pixels_due.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) step_limit = cfg_data_i;
      if (start_i && !busy_i)
        pixels_due.push_back(predict_pixel(start_real_i, start_imag_i, step_limit));
      if (result_valid_i) begin
        if (pixels_due.size() == 0) begin
          $error("pixel word with no point pending");
          errors_o++;
        end else begin
          want = pixels_due.pop_front();
          if (outcome_i != want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, outcome_i);
            errors_o++;
          end
          if (root_number_i != want.root) begin
            $error("root_number: expected %0d, got %0d", want.root, root_number_i);
            errors_o++;
          end
          if (palette_index_i != want.palette) begin
            $error("palette_index: expected %0d, got %0d", want.palette, palette_index_i);
            errors_o++;
          end
          if (iterations_i != want.iter) begin
            $error("iterations: expected %0d, got %0d", want.iter, iterations_i);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/newton_fractal_pixel_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_fractal_pixel_test - top of the Newton fractal pixel testbench
// Directed points at the reset limit, at a limit of zero and at the largest
// limit, then random points in phases with small step limits. The checker
// beside the block predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module newton_fractal_pixel_test;
  import nfp_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_POINTS = 290;
  localparam logic signed [31:0] Q_ONE = 32'sd268435456;   // 1.0 in Q4.28
  localparam logic signed [31:0] Q_HALF = 32'sd134217728;
  localparam logic signed [31:0] Q_RT3H = 32'sd232471924;  // sqrt(3)/2

  logic               clk_i, rst_ni;
  logic               start, busy;
  logic signed [31:0] start_real_i, start_imag_i;
  logic               cfg_valid_i, cfg_ready_o;
  logic [15:0]        cfg_data_i;
  logic               result_valid_o;
  logic [1:0]         outcome_o, root_number_o;
  logic [3:0]         palette_index_o;
  logic [15:0]        iterations_o;
  int                 errors, pending, points_sent, limits_used;
  int                 idle_cycles = 0;

  newton_fractal_pixel dut (.*);

  newton_fractal_pixel_checker scoreboard (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .start_real_i, .start_imag_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i, .result_valid_i(result_valid_o),
    .outcome_i(outcome_o), .root_number_i(root_number_o), .palette_index_i(palette_index_o),
    .iterations_i(iterations_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("newton_fractal_pixel_test: done, errors");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // one point word; called at a falling edge, returns at one
  task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    start_real_i <= re;
    start_imag_i <= im;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    points_sent++;
  endtask

  // register word, only once every pixel is out
  task automatic set_limit(input logic [15:0] limit);
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    limits_used++;
  endtask

  function automatic logic signed [31:0] near(input logic signed [31:0] c);
    return c + (int'($urandom_range(0, 1 << 25)) - (1 << 24));
  endfunction

  initial begin
    int kind, root_sel;
    logic signed [31:0] re, im;
    start = 1'b0;
    start_real_i = '0;
    start_imag_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    points_sent = 0;
    limits_used = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset limit: zero derivative, exact and near roots, far corners
    send_point(32'sd0, 32'sd0);
    send_point(32'sd1, -32'sd1);
    send_point(Q_ONE, 32'sd0);
    send_point(-Q_HALF, Q_RT3H);
    send_point(-Q_HALF, -Q_RT3H);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'sd0, 32'h8000_0000);
    send_point(Q_ONE <<< 1, 32'sd0);
    send_point(Q_HALF, Q_HALF);
    send_point(-Q_ONE, 32'sd0);
    send_point(near(Q_ONE), near(32'sd0));

    // limit of zero: no step and no check
    set_limit(16'd0);
    send_point(Q_ONE, 32'sd0);
    send_point(32'h7FFF_FFFF, 32'sd0);

    // largest limit, only with points that stop at once
    set_limit(16'hFFFF);
    send_point(32'sd0, 32'sd0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(Q_ONE, 32'sd0);
    send_point(-Q_HALF, -Q_RT3H);

    // random phases, each with its own small step limit
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n % 40 == 0) set_limit((n == 0) ? 16'd1 : 16'($urandom_range(1, 8)));
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        root_sel = $urandom_range(0, 2);
        re = near(root_sel == 0 ? Q_ONE : -Q_HALF);
        im = near(root_sel == 0 ? 32'sd0 : (root_sel == 1 ? Q_RT3H : -Q_RT3H));
      end else if (kind < 15) begin
        re = int'($urandom_range(0, 1 << 30)) - (1 << 29);
        im = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      end else begin
        re = $urandom;
        im = $urandom;
      end
      send_point(re, im);
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (500) @(posedge clk_i);
    $display("covered %0d points over %0d step limits (reset, zero, largest, random 1..8)",
             points_sent, limits_used + 1);
    if (errors == 0 && pending == 0)
      $display("newton_fractal_pixel_test: done, clean");
    else
      $display("newton_fractal_pixel_test: done, errors");
    $finish;
  end

endmodule
